// File: src/dbhm_pkg.sv
`default_nettype none

package dbhm_pkg;

	// fixed field widths
	localparam int LEVEL_WIDTH     = 17;
	localparam int SCALE_WIDTH     = 18;
	localparam int SCALE_FRAC_BITS = 16;
	localparam int CHAN_WIDTH      = 8;
	localparam int POS_WIDTH       = LEVEL_WIDTH + SCALE_WIDTH;

	// parameter defaults
	localparam int DEF_LEVEL_FRAC_BITS = 8;
	localparam int DEF_BLEND_FRAC_BITS = 8;

	// colour table
	localparam int TABLE_LEN   = 19;
	localparam int LAST_INDEX  = TABLE_LEN - 1;
	localparam int TAB_IDX_W   = $clog2(TABLE_LEN);

	localparam logic [SCALE_WIDTH-1:0] STEP_SCALE_RESET = SCALE_WIDTH'(9830);

	typedef struct packed {
		logic [CHAN_WIDTH-1:0] r;
		logic [CHAN_WIDTH-1:0] g;
		logic [CHAN_WIDTH-1:0] b;
	} rgb_t;

	localparam rgb_t HEAT_TABLE [TABLE_LEN] = '{
		'{8'd255, 8'd255, 8'd255},
		'{8'd240, 8'd254, 8'd216},
		'{8'd242, 8'd251, 8'd185},
		'{8'd253, 8'd245, 8'd143},
		'{8'd253, 8'd200, 8'd102},
		'{8'd252, 8'd144, 8'd66},
		'{8'd252, 8'd75,  8'd32},
		'{8'd237, 8'd28,  8'd41},
		'{8'd214, 8'd3,   8'd64},
		'{8'd183, 8'd3,   8'd101},
		'{8'd157, 8'd3,   8'd122},
		'{8'd122, 8'd3,   8'd126},
		'{8'd80,  8'd2,   8'd110},
		'{8'd45,  8'd2,   8'd89},
		'{8'd19,  8'd2,   8'd70},
		'{8'd1,   8'd3,   8'd53},
		'{8'd1,   8'd3,   8'd37},
		'{8'd1,   8'd2,   8'd19},
		'{8'd0,   8'd0,   8'd0}
	};

	localparam rgb_t COLOUR_WHITE = HEAT_TABLE[0];

endpackage

`default_nettype wire

// File: src/dbhm_blend.sv
`default_nettype none

// Linear blend of two channel values, rounding half up
module dbhm_blend #(
	parameter int BLEND_FRAC_BITS = dbhm_pkg::DEF_BLEND_FRAC_BITS
) (
	input  wire logic [dbhm_pkg::CHAN_WIDTH-1:0] a,
	input  wire logic [dbhm_pkg::CHAN_WIDTH-1:0] b,
	input  wire logic [BLEND_FRAC_BITS-1:0]      frac,
	output logic      [dbhm_pkg::CHAN_WIDTH-1:0] y
);
	import dbhm_pkg::*;

	localparam int WW = BLEND_FRAC_BITS + 1;
	localparam int SW = CHAN_WIDTH + WW + 1;

	localparam logic [WW-1:0] ONE  = WW'(1) << BLEND_FRAC_BITS;
	localparam logic [SW-1:0] HALF = SW'(1) << (BLEND_FRAC_BITS - 1);

	logic [WW-1:0] w_a;
	logic [SW-1:0] sum;

	// weight a by the complement, b by the fraction
	always_comb begin
		w_a = ONE - {1'b0, frac};
		sum = SW'(a) * SW'(w_a) + SW'(b) * SW'(frac) + HALF;
		y   = sum[BLEND_FRAC_BITS +: CHAN_WIDTH];
	end

endmodule

`default_nettype wire

// File: src/db_heatmap_colour_map_core.sv
`default_nettype none

// Channel   | Direction | Handshake                   | Payload
// level     | in        | level_valid / level_ready   | level_db (Q8.8, signed)
// colour    | out       | colour_valid / colour_ready | red, green, blue
// step_scale| config    | step_scale_we               | step_scale_wdata (Q2.16)
//
// One request per clock sustained while colour_ready is high; four register
// stages (magnitude, multiply, lookup, blend), and colour_valid is the valid bit
// of the blend stage, the last of them.
// The 17x18 position multiply and the table lookup set the stage depth.
// arst_n clears all valid bits and loads step_scale with the -120 dB floor.
// Each stage takes a new request when empty or when the next one moves, so
// a stalled output holds its request and bubbles upstream still close up.
module db_heatmap_colour_map_core #(
	parameter int LEVEL_FRAC_BITS = dbhm_pkg::DEF_LEVEL_FRAC_BITS,
	parameter int BLEND_FRAC_BITS = dbhm_pkg::DEF_BLEND_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               step_scale_we,
	input  wire logic [dbhm_pkg::SCALE_WIDTH-1:0]   step_scale_wdata,
	input  wire logic                               level_valid,
	output logic                                    level_ready,
	input  wire logic signed [dbhm_pkg::LEVEL_WIDTH-1:0] level_db,
	output logic                                    colour_valid,
	input  wire logic                               colour_ready,
	output logic      [dbhm_pkg::CHAN_WIDTH-1:0]    red,
	output logic      [dbhm_pkg::CHAN_WIDTH-1:0]    green,
	output logic      [dbhm_pkg::CHAN_WIDTH-1:0]    blue
);
	import dbhm_pkg::*;

	localparam int POS_FRAC_BITS = LEVEL_FRAC_BITS + SCALE_FRAC_BITS;
	localparam int IDX_W         = POS_WIDTH - POS_FRAC_BITS;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LAST_INDEX);

	logic [SCALE_WIDTH-1:0] step_scale_q;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic                   rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic                   neg_s1, neg_s2;
	logic [LEVEL_WIDTH-1:0] mag_s1;
	logic [POS_WIDTH-1:0]   pos_s2;
	rgb_t                   col_a_s3, col_b_s3;
	logic [BLEND_FRAC_BITS-1:0] frac_s3;
	rgb_t                   col_s4;

	logic [IDX_W-1:0]       idx;
	logic                   is_black;
	logic [TAB_IDX_W-1:0]   tsel;
	rgb_t                   col_a, col_b, col_blend;
	logic [BLEND_FRAC_BITS-1:0] frac;

	// hold the step scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_scale_q <= STEP_SCALE_RESET;
		end else if (step_scale_we) begin
			step_scale_q <= step_scale_wdata;
		end
	end

	// per-stage ready: take a request when empty or when it moves on
	always_comb begin
		rdy_s4 = !v_s4 || colour_ready;
		rdy_s3 = !v_s3 || rdy_s4;
		rdy_s2 = !v_s2 || rdy_s3;
		rdy_s1 = !v_s1 || rdy_s2;
	end

	assign level_ready = rdy_s1;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= level_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 3 lookup: a non-negative level is white, else the integer part picks the entry, at or past the last is black
	always_comb begin
		idx      = pos_s2[POS_WIDTH-1:POS_FRAC_BITS];
		is_black = neg_s2 && (idx >= IDX_LAST);
		tsel     = is_black ? TAB_IDX_W'(LAST_INDEX) : idx[TAB_IDX_W-1:0];
		frac     = pos_s2[POS_FRAC_BITS-1 -: BLEND_FRAC_BITS];
		if (!neg_s2) begin
			col_a = COLOUR_WHITE;
			col_b = COLOUR_WHITE;
			frac  = '0;
		end else if (is_black) begin
			col_a = HEAT_TABLE[LAST_INDEX];
			col_b = HEAT_TABLE[LAST_INDEX];
			frac  = '0;
		end else begin
			col_a = HEAT_TABLE[tsel];
			col_b = HEAT_TABLE[tsel + TAB_IDX_W'(1)];
		end
	end

	// stage 4 blend, one unit per channel
	dbhm_blend #(.BLEND_FRAC_BITS(BLEND_FRAC_BITS)) u_blend_r (
		.a(col_a_s3.r), .b(col_b_s3.r), .frac(frac_s3), .y(col_blend.r)
	);
	dbhm_blend #(.BLEND_FRAC_BITS(BLEND_FRAC_BITS)) u_blend_g (
		.a(col_a_s3.g), .b(col_b_s3.g), .frac(frac_s3), .y(col_blend.g)
	);
	dbhm_blend #(.BLEND_FRAC_BITS(BLEND_FRAC_BITS)) u_blend_b (
		.a(col_a_s3.b), .b(col_b_s3.b), .frac(frac_s3), .y(col_blend.b)
	);

	// advance payload
	always_ff @(posedge clk) begin
		if (level_valid && rdy_s1) begin
			neg_s1 <= level_db[LEVEL_WIDTH-1];
			mag_s1 <= ~level_db + LEVEL_WIDTH'(1);
		end
		if (v_s1 && rdy_s2) begin
			neg_s2 <= neg_s1;
			pos_s2 <= {{SCALE_WIDTH{1'b0}}, mag_s1} * {{LEVEL_WIDTH{1'b0}}, step_scale_q};
		end
		if (v_s2 && rdy_s3) begin
			col_a_s3 <= col_a;
			col_b_s3 <= col_b;
			frac_s3  <= frac;
		end
		if (v_s3 && rdy_s4) begin
			col_s4 <= col_blend;
		end
	end

	assign colour_valid = v_s4;
	assign red          = col_s4.r;
	assign green        = col_s4.g;
	assign blue         = col_s4.b;

endmodule

`default_nettype wire

// File: src/dbhm_checker.sv
`default_nettype none

module dbhm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        level_valid,
	input wire logic        level_ready,
	input wire logic [16:0] level_db,
	input wire logic        colour_valid,
	input wire logic        colour_ready,
	input wire logic [7:0]  red,
	input wire logic [7:0]  green,
	input wire logic [7:0]  blue
);

	logic       acc_in, acc_out;
	logic [2:0] cnt_q;

	assign acc_in  = level_valid && level_ready;
	assign acc_out = colour_valid && colour_ready;

	// track requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(acc_in) - 3'(acc_out);
		end
	end

	// hold a stalled colour
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		colour_valid && !colour_ready |=>
			colour_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("colour changed while stalled");

	// never more in flight than stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_q > 3'd4) && (!colour_valid || cnt_q != 3'd0))
		else $error("in-flight count out of range");

	// backpressure only comes from a stalled output
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!level_ready |-> colour_valid && !colour_ready)
		else $error("input stalled with output free");

	// a level at or above zero comes out white once the output has stayed ready
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && !level_db[16]) ##1 colour_ready ##1 colour_ready ##1 colour_ready |=>
			colour_valid && red == 8'hFF && green == 8'hFF && blue == 8'hFF)
		else $error("non-negative level not white");

endmodule

bind db_heatmap_colour_map_core dbhm_checker u_dbhm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.level_valid  (level_valid),
	.level_ready  (level_ready),
	.level_db     (level_db),
	.colour_valid (colour_valid),
	.colour_ready (colour_ready),
	.red          (red),
	.green        (green),
	.blue         (blue)
);

`default_nettype wire

// File: test/tb_db_heatmap_colour_map_core.sv
`default_nettype none

module tb_db_heatmap_colour_map_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dbhm_pkg::*;

	localparam int POS_FRAC    = DEF_LEVEL_FRAC_BITS + SCALE_FRAC_BITS;
	localparam int BLEND_BITS  = DEF_BLEND_FRAC_BITS;
	localparam int BLEND_ONE   = 1 << BLEND_BITS;
	localparam int BLEND_HALF  = 1 << (BLEND_BITS - 1);
	localparam int PIPE_DEPTH  = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [SCALE_WIDTH-1:0] SCALE_MAX = {SCALE_WIDTH{1'b1}};

	localparam logic signed [LEVEL_WIDTH-1:0] DIRECTED_LEVELS [20] = '{
		17'sd0, 17'sd1, 17'sd65535, 17'sd256, -17'sd1, 17'h10000,
		-17'sd128, -17'sd256, -17'sd2560, -17'sd2561, -17'sd5120, -17'sd10240,
		-17'sd15360, -17'sd20480, -17'sd25600, -17'sd28160, -17'sd30720,
		-17'sd30721, -17'sd30976, -17'sd40000
	};

	// Expected colours for accepted level requests, oldest first
	class colour_scoreboard;
		rgb_t                   colour_q[$];
		logic [SCALE_WIDTH-1:0] scale;
		int                     errors;

		function new();
			scale  = STEP_SCALE_RESET;
			errors = 0;
		endfunction

		function void set_scale(logic [SCALE_WIDTH-1:0] value);
			scale = value;
		endfunction

		function int pending();
			return colour_q.size();
		endfunction

		function logic [CHAN_WIDTH-1:0] mix_channel(int unsigned a, int unsigned b,
				int unsigned f);
			return CHAN_WIDTH'((a * (BLEND_ONE - f) + b * f + BLEND_HALF) >> BLEND_BITS);
		endfunction

		// Map a Q8.8 level to its heat-map colour
		function rgb_t map_level(logic signed [LEVEL_WIDTH-1:0] level);
			logic [63:0] mag;
			logic [63:0] pos;
			int unsigned idx;
			int unsigned frac;
			rgb_t        lo;
			rgb_t        hi;
			rgb_t        res;
			if (!level[LEVEL_WIDTH-1]) begin
				return COLOUR_WHITE;
			end
			mag = (64'd1 << LEVEL_WIDTH) - {47'd0, level};
			pos = mag * {46'd0, scale};
			idx = int'(pos >> POS_FRAC);
			if (idx >= LAST_INDEX) begin
				return HEAT_TABLE[LAST_INDEX];
			end
			frac  = int'((pos >> (POS_FRAC - BLEND_BITS)) & ((64'd1 << BLEND_BITS) - 1));
			lo    = HEAT_TABLE[idx];
			hi    = HEAT_TABLE[idx + 1];
			res.r = mix_channel(lo.r, hi.r, frac);
			res.g = mix_channel(lo.g, hi.g, frac);
			res.b = mix_channel(lo.b, hi.b, frac);
			return res;
		endfunction

		function void note_level(logic signed [LEVEL_WIDTH-1:0] level);
			colour_q.push_back(map_level(level));
		endfunction

		function void compare_field(string name, logic [CHAN_WIDTH-1:0] want,
				logic [CHAN_WIDTH-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
				errors++;
			end
		endfunction

		function void check_colour(rgb_t got);
			rgb_t want;
			if (colour_q.size() == 0) begin
				$display("%0t: unexpected colour request, got %0d %0d %0d",
					$realtime, got.r, got.g, got.b);
				errors++;
				return;
			end
			want = colour_q.pop_front();
			compare_field("red", want.r, got.r);
			compare_field("green", want.g, got.g);
			compare_field("blue", want.b, got.b);
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          step_scale_we;
	logic [SCALE_WIDTH-1:0]        step_scale_wdata;
	logic                          level_valid;
	logic                          level_ready;
	logic signed [LEVEL_WIDTH-1:0] level_db;
	logic                          colour_valid;
	logic                          colour_ready;
	logic [CHAN_WIDTH-1:0]         red;
	logic [CHAN_WIDTH-1:0]         green;
	logic [CHAN_WIDTH-1:0]         blue;

	colour_scoreboard board;
	bit               calm;
	bit               hold_request;
	int               stall_left;
	int               hold_left;

	db_heatmap_colour_map_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_scale_we    (step_scale_we),
		.step_scale_wdata (step_scale_wdata),
		.level_valid      (level_valid),
		.level_ready      (level_ready),
		.level_db         (level_db),
		.colour_valid     (colour_valid),
		.colour_ready     (colour_ready),
		.red              (red),
		.green            (green),
		.blue             (blue)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort a run that hangs
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_db_heatmap_colour_map_core: FAIL");
		$finish;
	end

	// Colour side: random stalls, one long hold-off on request, check each colour
	initial begin
		colour_ready = 1'b0;
		stall_left   = 0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				colour_ready <= 1'b0;
			end else if (calm) begin
				colour_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				colour_ready <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				colour_ready <= 1'b0;
			end else begin
				colour_ready <= 1'b1;
			end
			@(posedge clk);
			if (colour_valid && colour_ready) begin
				board.check_colour('{red, green, blue});
			end
		end
	end

	// Hold the level channel idle with junk on the payload
	task automatic sender_pause(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			level_valid <= 1'b0;
			level_db    <= LEVEL_WIDTH'($urandom);
		end
	endtask

	// Offer one level request and wait for it to be taken
	task automatic send_level(logic signed [LEVEL_WIDTH-1:0] level, bit gaps);
		if (gaps && !calm && $urandom_range(0, 7) == 0) begin
			sender_pause($urandom_range(1, 18));
		end
		@(negedge clk);
		level_valid <= 1'b1;
		level_db    <= level;
		@(posedge clk);
		while (!level_ready) @(posedge clk);
		board.note_level(level);
	endtask

	// Drop valid and let every outstanding colour drain out of the pipe
	task automatic drain_pipe();
		@(negedge clk);
		level_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_step_scale(logic [SCALE_WIDTH-1:0] value);
		drain_pipe();
		@(negedge clk);
		step_scale_we    <= 1'b1;
		step_scale_wdata <= value;
		board.set_scale(value);
		@(negedge clk);
		step_scale_we <= 1'b0;
	endtask

	// Pick a level, mostly negative within reach of the table at this scale
	function automatic logic signed [LEVEL_WIDTH-1:0] pick_level(logic [SCALE_WIDTH-1:0] scale);
		int unsigned reach;
		int unsigned mag;
		int unsigned edge_pick;
		if (scale == 0) begin
			reach = 65536;
		end else begin
			reach = 32'd301989888 / scale;
			reach = reach + reach / 8 + 1;
			if (reach > 65536) begin
				reach = 65536;
			end
		end
		case ($urandom_range(0, 9))
			0, 1: begin
				return LEVEL_WIDTH'($urandom);
			end
			2: begin
				return LEVEL_WIDTH'($urandom_range(0, 65535));
			end
			3: begin
				edge_pick = $urandom_range(0, 3);
				case (edge_pick)
					0:       return 17'sd0;
					1:       return -17'sd1;
					2:       return 17'h10000;
					default: return 17'sd65535;
				endcase
			end
			default: begin
				mag = $urandom_range(1, reach);
				return LEVEL_WIDTH'(0 - mag);
			end
		endcase
	endfunction

	task automatic run_phase(logic [SCALE_WIDTH-1:0] scale, int count, bit pressure);
		write_step_scale(scale);
		if (pressure) begin
			hold_request = 1'b1;
		end
		for (int i = 0; i < count; i++) begin
			send_level(pick_level(scale), !(pressure && i < 40));
		end
	endtask

	initial begin
		board            = new();
		calm             = 1'b0;
		hold_request     = 1'b0;
		arst_n           = 1'b0;
		step_scale_we    = 1'b0;
		step_scale_wdata = '0;
		level_valid      = 1'b0;
		level_db         = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed levels at the reset floor of -120 dB
		foreach (DIRECTED_LEVELS[i]) begin
			send_level(DIRECTED_LEVELS[i], 1'b1);
		end

		run_phase(SCALE_MAX, 100, 1'b0);
		run_phase(SCALE_WIDTH'(1), 80, 1'b0);
		run_phase(SCALE_WIDTH'(0), 12, 1'b0);
		run_phase(STEP_SCALE_RESET, 120, 1'b1);
		run_phase(SCALE_WIDTH'($urandom_range(1, 262143)), 100, 1'b0);
		run_phase(SCALE_WIDTH'(1179648 / $urandom_range(20, 180)), 100, 1'b0);
		run_phase(SCALE_WIDTH'(1179648 / $urandom_range(20, 180)), 100, 1'b0);

		// Last stretch runs flat out on both sides
		calm = 1'b1;
		run_phase(SCALE_WIDTH'(1179648 / $urandom_range(20, 180)), 120, 1'b0);

		drain_pipe();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb_db_heatmap_colour_map_core: PASS");
		end else begin
			$display("tb_db_heatmap_colour_map_core: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
src/dbhm_pkg.sv
src/dbhm_blend.sv
src/db_heatmap_colour_map_core.sv
src/dbhm_checker.sv
test/tb_db_heatmap_colour_map_core.sv
